// ===== rtl/core/mtep_pkg.sv =====
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int LENGTH_BYTES_MAX_DEF = 4;
  localparam int FREQ_FRAC_BITS_DEF   = 4;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_A4    = 69;
  localparam int FREQ_A4    = 440;

  localparam logic [7:0] CHAN_STATUS_LO = 8'h80;
  localparam logic [7:0] CHAN_STATUS_HI = 8'hEF;
  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE   = 8'hF7;
  localparam logic [7:0] META_STATUS    = 8'hFF;
  localparam logic [7:0] META_EOT       = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] TEMPO_LENGTH   = 8'h03;
  localparam logic [7:0] DATA_MASK      = 8'b01111111;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_PROGRAM  = 4'hC;
  localparam logic [3:0] MSG_PRESSURE = 4'hD;

  typedef enum logic [3:0] {
    PH_DELTA      = 4'd0,
    PH_STATUS     = 4'd1,
    PH_DATA       = 4'd2,
    PH_META_TYPE  = 4'd3,
    PH_EOT_LEN    = 4'd4,
    PH_TEMPO_LEN  = 4'd5,
    PH_TEMPO_DATA = 4'd6,
    PH_SKIP_LEN   = 4'd7,
    PH_SKIP       = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DELTA     = 3'd0,
    KIND_NOTE_ON   = 3'd1,
    KIND_NOTE_OFF  = 3'd2,
    KIND_TEMPO     = 3'd3,
    KIND_END       = 3'd4,
    KIND_BAD_TEMPO = 3'd5
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] track_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [27:0] delta_ticks;
    logic [6:0]  note_number;
    logic [17:0] tone_frequency;
    logic [23:0] tempo_value;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } parse_result_t;

  typedef logic [17:0] tone_table_t [NOTE_COUNT];

  localparam logic [63:0] SEMI_SCALE = 64'd100000000000;
  localparam logic [63:0] SEMI_RATIO [12] = '{
    64'd100000000000, 64'd105946309436, 64'd112246204831, 64'd118920711500,
    64'd125992104989, 64'd133483985417, 64'd141421356237, 64'd149830707688,
    64'd158740105197, 64'd168179283051, 64'd178179743628, 64'd188774862536
  };

  // round(440 * 2^((n-69)/12) * 2^frac_bits), low 18 bits
  function automatic tone_table_t build_tone_table(int frac_bits);
    tone_table_t  tbl;
    logic [127:0] num;
    logic [127:0] quo;
    int           rel;
    int           oct;
    int           semi;
    int           sh;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      rel  = n + 72 - NOTE_A4;
      oct  = rel / 12 - 6;
      semi = rel % 12;
      sh   = oct + frac_bits;
      num  = 128'(FREQ_A4) * 128'(SEMI_RATIO[semi]);
      if (sh >= 0) begin
        quo = ((num << sh) + 128'(SEMI_SCALE / 2)) / SEMI_SCALE;
      end else begin
        quo = ((num + (128'(SEMI_SCALE) << (-sh - 1))) >> (-sh)) / SEMI_SCALE;
      end
      tbl[n] = quo[17:0];
    end
    return tbl;
  endfunction

endpackage

// ===== rtl/core/mtep_parser.sv =====
`timescale 1ns / 1ps

module mtep_parser import mtep_pkg::*; #(
  parameter int LENGTH_BYTES_MAX = LENGTH_BYTES_MAX_DEF,
  parameter int FREQ_FRAC_BITS   = FREQ_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  in_beat_t      beat,
  output parse_result_t result,
  output logic          ended
);

  localparam int CntW = $clog2(LENGTH_BYTES_MAX + 1);
  localparam tone_table_t ToneTable = build_tone_table(FREQ_FRAC_BITS);

  phase_t      phase, phase_next;
  logic [27:0] acc, acc_next;
  logic [27:0] skip, skip_next;
  logic [1:0]  dbl, dbl_next;
  logic [3:0]  msg, msg_next;
  logic [6:0]  note, note_next;
  logic [23:0] tempo, tempo_next;
  logic        track_ended, track_ended_next;
  logic [CntW-1:0] cnt, cnt_next;

  logic [7:0]      b;
  logic            feed_clear;
  logic [27:0]     acc_in;
  logic [CntW-1:0] cnt_in;
  logic [27:0]     fed_acc;
  logic [CntW-1:0] fed_cnt;
  logic            fed_done;
  logic [1:0]      dbl_dec;
  logic [27:0]     skip_dec;

  assign b          = beat.track_byte;
  assign feed_clear = (phase != PH_DELTA) && (phase != PH_SKIP_LEN);
  assign acc_in     = feed_clear ? '0 : acc;
  assign cnt_in     = feed_clear ? '0 : cnt;
  assign fed_acc    = {acc_in[20:0], b[6:0]};
  assign fed_cnt    = cnt_in + 1'b1;
  assign fed_done   = !b[7] || (fed_cnt >= CntW'(LENGTH_BYTES_MAX));
  assign dbl_dec    = dbl - 2'd1;
  assign skip_dec   = skip - 28'd1;
  assign ended      = track_ended;

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    skip_next        = skip;
    dbl_next         = dbl;
    msg_next         = msg;
    note_next        = note;
    tempo_next       = tempo;
    track_ended_next = track_ended;
    cnt_next         = cnt;
    result           = '0;

    if (step) begin
      if (beat.mode) begin
        phase_next       = PH_DELTA;
        acc_next         = '0;
        skip_next        = '0;
        dbl_next         = '0;
        msg_next         = '0;
        note_next        = '0;
        tempo_next       = '0;
        track_ended_next = 1'b0;
        cnt_next         = '0;
      end else if (!track_ended) begin
        unique case (phase)
          PH_STATUS: begin
            if (b >= CHAN_STATUS_LO && b <= CHAN_STATUS_HI) begin
              msg_next   = b[7:4];
              dbl_next   = (b[7:4] == MSG_PROGRAM || b[7:4] == MSG_PRESSURE) ? 2'd1 : 2'd2;
              phase_next = PH_DATA;
            end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
              acc_next   = '0;
              cnt_next   = '0;
              phase_next = PH_SKIP_LEN;
            end else if (b == META_STATUS) begin
              phase_next = PH_META_TYPE;
            end else begin
              acc_next   = '0;
              cnt_next   = '0;
              phase_next = PH_DELTA;
            end
          end
          PH_DATA: begin
            if (msg == MSG_NOTE_ON && dbl == 2'd2) begin
              note_next = b[6:0] & DATA_MASK[6:0];
            end
            dbl_next = dbl_dec;
            if (dbl_dec == 2'd0) begin
              if (msg == MSG_NOTE_ON) begin
                result.valid               = 1'b1;
                result.beat.event_kind     = KIND_NOTE_ON;
                result.beat.note_number    = note_next;
                result.beat.tone_frequency = ToneTable[note_next];
              end else if (msg == MSG_NOTE_OFF) begin
                result.valid           = 1'b1;
                result.beat.event_kind = KIND_NOTE_OFF;
              end
              acc_next   = '0;
              cnt_next   = '0;
              phase_next = PH_DELTA;
            end
          end
          PH_META_TYPE: begin
            if (b == META_EOT) begin
              phase_next = PH_EOT_LEN;
            end else if (b == META_TEMPO) begin
              phase_next = PH_TEMPO_LEN;
            end else begin
              acc_next   = '0;
              cnt_next   = '0;
              phase_next = PH_SKIP_LEN;
            end
          end
          PH_EOT_LEN: begin
            result.valid           = 1'b1;
            result.beat.event_kind = KIND_END;
            track_ended_next       = 1'b1;
            acc_next               = '0;
            cnt_next               = '0;
            phase_next             = PH_DELTA;
          end
          PH_TEMPO_LEN: begin
            if (b == TEMPO_LENGTH) begin
              tempo_next = '0;
              dbl_next   = 2'd3;
              phase_next = PH_TEMPO_DATA;
            end else begin
              result.valid           = 1'b1;
              result.beat.event_kind = KIND_BAD_TEMPO;
              track_ended_next       = 1'b1;
              acc_next               = '0;
              cnt_next               = '0;
              phase_next             = PH_DELTA;
            end
          end
          PH_TEMPO_DATA: begin
            tempo_next = {tempo[15:0], b};
            dbl_next   = dbl_dec;
            if (dbl_dec == 2'd0) begin
              result.valid            = 1'b1;
              result.beat.event_kind  = KIND_TEMPO;
              result.beat.tempo_value = {tempo[15:0], b};
              acc_next                = '0;
              cnt_next                = '0;
              phase_next              = PH_DELTA;
            end
          end
          PH_SKIP_LEN: begin
            acc_next = fed_acc;
            cnt_next = fed_done ? '0 : fed_cnt;
            if (fed_done) begin
              skip_next = fed_acc;
              if (fed_acc == 28'd0) begin
                acc_next   = '0;
                phase_next = PH_DELTA;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            skip_next = skip_dec;
            if (skip_dec == 28'd0) begin
              acc_next   = '0;
              cnt_next   = '0;
              phase_next = PH_DELTA;
            end
          end
          default: begin
            acc_next   = fed_acc;
            cnt_next   = fed_done ? '0 : fed_cnt;
            phase_next = PH_DELTA;
            if (fed_done) begin
              result.valid            = 1'b1;
              result.beat.event_kind  = KIND_DELTA;
              result.beat.delta_ticks = fed_acc;
              phase_next              = PH_STATUS;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DELTA;
      acc         <= '0;
      skip        <= '0;
      dbl         <= '0;
      msg         <= '0;
      note        <= '0;
      tempo       <= '0;
      track_ended <= 1'b0;
      cnt         <= '0;
    end else begin
      phase       <= phase_next;
      acc         <= acc_next;
      skip        <= skip_next;
      dbl         <= dbl_next;
      msg         <= msg_next;
      note        <= note_next;
      tempo       <= tempo_next;
      track_ended <= track_ended_next;
      cnt         <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/midi_track_event_parser.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Beat
// in        in   in_valid/in_stall    in_beat_t  {mode, track_byte}
// out       out  out_valid/out_stall  out_beat_t {event_kind, delta_ticks,
//                                      note_number, tone_frequency, tempo_value}
//
// One byte per cycle while in_stall is low: a beat lands in the input register,
// the parser decodes it from there and its event (if any) is then registered
// in the output register.
// The input register takes one more beat while an event waits on out_stall;
// it stalls only when it is full and the output register cannot be freed.
// Reset clears the parser state and both valid flags; no clearing pass.

module midi_track_event_parser import mtep_pkg::*; #(
  parameter int LENGTH_BYTES_MAX = LENGTH_BYTES_MAX_DEF,
  parameter int FREQ_FRAC_BITS   = FREQ_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic          hold_valid;
  in_beat_t      hold_data;
  logic          advance;
  parse_result_t result;
  logic          ended;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  mtep_parser #(
    .LENGTH_BYTES_MAX(LENGTH_BYTES_MAX),
    .FREQ_FRAC_BITS  (FREQ_FRAC_BITS)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .beat  (hold_data),
    .result(result),
    .ended (ended)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_data <= result.beat;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && out_valid && out_stall))
    else $error("input stalled without a blocked event");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && ended && !hold_data.mode) |-> !result.valid)
    else $error("event produced after end of track");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && result.valid))
    else $error("output beat without a parsed byte");

endmodule

// ===== bench/midi_track_event_parser_checker.sv =====
`timescale 1ns / 1ps

module midi_track_event_parser_checker import mtep_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        failures,
  output int        pending
);

  localparam int VLQ_BYTES_MAX = LENGTH_BYTES_MAX_DEF;
  localparam int FRAC_BITS     = FREQ_FRAC_BITS_DEF;

  phase_t      phase;
  logic [27:0] vlq_value;
  int          vlq_bytes;
  logic [27:0] skip_left;
  logic [1:0]  data_left;
  logic [3:0]  msg_type;
  logic [6:0]  held_note;
  logic [23:0] tempo_acc;
  logic        ended;
  int          mismatches;

  out_beat_t   expected_events[$];

  function automatic logic [17:0] note_frequency(logic [6:0] note);
    int              rel;
    int              shift;
    longint unsigned num;
    longint unsigned den;
    rel   = int'(note) + 3;
    shift = rel / 12 - 6 + FRAC_BITS;
    num   = 64'(FREQ_A4) * SEMI_RATIO[rel % 12];
    den   = SEMI_SCALE;
    if (shift >= 0) begin
      num = num << shift;
    end else begin
      den = den << (-shift);
    end
    return 18'((num + den / 2) / den);
  endfunction

  function automatic void restart_parser();
    phase     = PH_DELTA;
    vlq_value = '0;
    vlq_bytes = 0;
    skip_left = '0;
    data_left = '0;
    msg_type  = '0;
    held_note = '0;
    tempo_acc = '0;
    ended     = 1'b0;
  endfunction

  function automatic void begin_length(phase_t next);
    vlq_value = '0;
    vlq_bytes = 0;
    phase     = next;
  endfunction

  function automatic bit length_done(logic [7:0] b);
    vlq_value = {vlq_value[20:0], b[6:0]};
    vlq_bytes++;
    if (!b[7] || vlq_bytes >= VLQ_BYTES_MAX) begin
      vlq_bytes = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit decode_track_byte(in_beat_t beat, output out_beat_t ev);
    logic [7:0] b;
    bit         hit;
    b   = beat.track_byte;
    hit = 1'b0;
    ev  = '0;
    if (beat.mode) begin
      restart_parser();
    end else if (!ended) begin
      case (phase)
        PH_STATUS: begin
          if (b >= CHAN_STATUS_LO && b <= CHAN_STATUS_HI) begin
            msg_type  = b[7:4];
            data_left = (msg_type == MSG_PROGRAM || msg_type == MSG_PRESSURE) ? 2'd1 : 2'd2;
            phase     = PH_DATA;
          end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
            begin_length(PH_SKIP_LEN);
          end else if (b == META_STATUS) begin
            phase = PH_META_TYPE;
          end else begin
            begin_length(PH_DELTA);
          end
        end
        PH_DATA: begin
          if (msg_type == MSG_NOTE_ON && data_left == 2'd2) begin
            held_note = b[6:0];
          end
          data_left = data_left - 2'd1;
          if (data_left == 2'd0) begin
            if (msg_type == MSG_NOTE_ON) begin
              hit               = 1'b1;
              ev.event_kind     = KIND_NOTE_ON;
              ev.note_number    = held_note;
              ev.tone_frequency = note_frequency(held_note);
            end else if (msg_type == MSG_NOTE_OFF) begin
              hit           = 1'b1;
              ev.event_kind = KIND_NOTE_OFF;
            end
            begin_length(PH_DELTA);
          end
        end
        PH_META_TYPE: begin
          if (b == META_EOT) begin
            phase = PH_EOT_LEN;
          end else if (b == META_TEMPO) begin
            phase = PH_TEMPO_LEN;
          end else begin
            begin_length(PH_SKIP_LEN);
          end
        end
        PH_EOT_LEN: begin
          hit           = 1'b1;
          ev.event_kind = KIND_END;
          ended         = 1'b1;
          begin_length(PH_DELTA);
        end
        PH_TEMPO_LEN: begin
          if (b == TEMPO_LENGTH) begin
            tempo_acc = '0;
            data_left = 2'd3;
            phase     = PH_TEMPO_DATA;
          end else begin
            hit           = 1'b1;
            ev.event_kind = KIND_BAD_TEMPO;
            ended         = 1'b1;
            begin_length(PH_DELTA);
          end
        end
        PH_TEMPO_DATA: begin
          tempo_acc = {tempo_acc[15:0], b};
          data_left = data_left - 2'd1;
          if (data_left == 2'd0) begin
            hit            = 1'b1;
            ev.event_kind  = KIND_TEMPO;
            ev.tempo_value = tempo_acc;
            begin_length(PH_DELTA);
          end
        end
        PH_SKIP_LEN: begin
          if (length_done(b)) begin
            skip_left = vlq_value;
            if (skip_left == '0) begin
              begin_length(PH_DELTA);
            end else begin
              phase = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_left = skip_left - 28'd1;
          if (skip_left == '0) begin
            begin_length(PH_DELTA);
          end
        end
        default: begin
          if (length_done(b)) begin
            hit            = 1'b1;
            ev.event_kind  = KIND_DELTA;
            ev.delta_ticks = vlq_value;
            phase          = PH_STATUS;
          end
        end
      endcase
    end
    return hit;
  endfunction

  function automatic int field_differs(string name, longint unsigned want,
                                       longint unsigned got);
    if (want == got) begin
      return 0;
    end
    $error("%s expected 0x%0h got 0x%0h", name, want, got);
    return 1;
  endfunction

  initial begin
    restart_parser();
  end

  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t ev;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("event_kind %0d arrived with no event expected", out_data.event_kind);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          mismatches += field_differs("event_kind", 64'(want.event_kind),
                                      64'(out_data.event_kind));
          mismatches += field_differs("delta_ticks", 64'(want.delta_ticks),
                                      64'(out_data.delta_ticks));
          mismatches += field_differs("note_number", 64'(want.note_number),
                                      64'(out_data.note_number));
          mismatches += field_differs("tone_frequency", 64'(want.tone_frequency),
                                      64'(out_data.tone_frequency));
          mismatches += field_differs("tempo_value", 64'(want.tempo_value),
                                      64'(out_data.tempo_value));
        end
      end
      if (in_valid && !in_stall && decode_track_byte(in_data, ev)) begin
        expected_events.push_back(ev);
      end
    end
    failures <= mismatches;
    pending  <= expected_events.size();
  end

endmodule

// ===== bench/midi_track_event_parser_test.sv =====
`timescale 1ns / 1ps

module midi_track_event_parser_test;
  import mtep_pkg::*;

  localparam int         TRACK_BEATS       = 500;
  localparam int         CYCLE_LIMIT       = 400000;
  localparam int         HOLD_OFF_CYCLES   = 120;
  localparam int         DRAIN_CYCLES      = 20;
  localparam logic [3:0] MSG_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] MSG_CONTROL       = 4'hB;
  localparam logic [3:0] MSG_PITCH_BEND    = 4'hE;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        failures;
  int        pending;
  int        sent = 0;
  int        cycle_count = 0;
  bit        steady = 1'b0;

  midi_track_event_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  midi_track_event_parser_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("midi_track_event_parser_test failed");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // hold off the sink once for a long stretch so the parser backs up
  initial begin : sink
    int  run;
    bit  held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (!held_off && sent >= 150) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        run = HOLD_OFF_CYCLES;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        run = 1 + idle_cycles();
      end
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_beat(input logic m, input logic [7:0] b, input bit counts = 1'b1);
    int gap;
    gap = steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: m, track_byte: b};
    do @(posedge clk); while (in_stall);
    if (counts) begin
      sent++;
    end
  endtask

  task automatic send_delta();
    int n;
    n = $urandom_range(1, LENGTH_BYTES_MAX_DEF);
    for (int i = 1; i <= n; i++) begin
      if (i < n || (n == LENGTH_BYTES_MAX_DEF && $urandom_range(0, 3) == 0)) begin
        send_beat(1'b0, 8'h80 | 8'($urandom_range(0, 127)));
      end else begin
        send_beat(1'b0, 8'($urandom_range(0, 127)));
      end
    end
  endtask

  task automatic send_skip_body();
    int size;
    size = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) begin
      send_beat(1'b0, 8'h80);
    end
    send_beat(1'b0, 8'(size));
    repeat (size) send_beat(1'b0, 8'($urandom));
  endtask

  // drop a few bytes past the end, then restart
  task automatic close_track();
    repeat ($urandom_range(0, 3)) send_beat(1'b0, 8'($urandom), 1'b0);
    send_beat(1'b1, 8'($urandom));
  endtask

  task automatic send_event();
    int         pick;
    logic [7:0] b;
    logic [3:0] msg;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_beat(1'b0, {MSG_NOTE_ON, 4'($urandom)});
      send_beat(1'b0, 8'($urandom));
      send_beat(1'b0, 8'($urandom));
    end else if (pick < 45) begin
      send_beat(1'b0, {MSG_NOTE_OFF, 4'($urandom)});
      send_beat(1'b0, 8'($urandom));
      send_beat(1'b0, 8'($urandom));
    end else if (pick < 55) begin
      case ($urandom_range(0, 2))
        0: msg = MSG_POLY_PRESSURE;
        1: msg = MSG_CONTROL;
        default: msg = MSG_PITCH_BEND;
      endcase
      send_beat(1'b0, {msg, 4'($urandom)});
      send_beat(1'b0, 8'($urandom));
      send_beat(1'b0, 8'($urandom));
    end else if (pick < 62) begin
      msg = $urandom_range(0, 1) ? MSG_PROGRAM : MSG_PRESSURE;
      send_beat(1'b0, {msg, 4'($urandom)});
      send_beat(1'b0, 8'($urandom));
    end else if (pick < 70) begin
      send_beat(1'b0, $urandom_range(0, 1) ? SYSEX_START : SYSEX_ESCAPE);
      send_skip_body();
    end else if (pick < 77) begin
      do b = 8'($urandom); while (b == META_EOT || b == META_TEMPO);
      send_beat(1'b0, META_STATUS);
      send_beat(1'b0, b);
      send_skip_body();
    end else if (pick < 88) begin
      send_beat(1'b0, META_STATUS);
      send_beat(1'b0, META_TEMPO);
      send_beat(1'b0, TEMPO_LENGTH);
      repeat (3) send_beat(1'b0, 8'($urandom));
    end else if (pick < 92) begin
      do b = 8'($urandom);
      while ((b >= CHAN_STATUS_LO && b <= CHAN_STATUS_HI) || b == SYSEX_START ||
             b == SYSEX_ESCAPE || b == META_STATUS);
      send_beat(1'b0, b);
    end else if (pick < 95) begin
      send_beat(1'b0, META_STATUS);
      send_beat(1'b0, META_EOT);
      send_beat(1'b0, $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
      close_track();
    end else if (pick < 97) begin
      do b = 8'($urandom); while (b == TEMPO_LENGTH);
      send_beat(1'b0, META_STATUS);
      send_beat(1'b0, META_TEMPO);
      send_beat(1'b0, b);
      close_track();
    end else if (pick < 98) begin
      send_beat(1'b1, 8'($urandom));
    end else begin
      send_beat(1'b0, 8'($urandom));
    end
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_beat(1'b0, 8'h00);
    send_beat(1'b0, {MSG_NOTE_ON, 4'h0});
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'h40);
    repeat (LENGTH_BYTES_MAX_DEF) send_beat(1'b0, 8'hFF);
    send_beat(1'b0, {MSG_NOTE_ON, 4'hF});
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'h7F);
    send_beat(1'b0, {MSG_NOTE_OFF, 4'hF});
    send_beat(1'b0, 8'h3C);
    send_beat(1'b0, 8'h40);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, {MSG_PRESSURE, 4'h5});
    send_beat(1'b0, 8'h10);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, META_STATUS);
    send_beat(1'b0, META_TEMPO);
    send_beat(1'b0, TEMPO_LENGTH);
    repeat (3) send_beat(1'b0, 8'hFF);

    while (sent < TRACK_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        steady = !steady;
      end
      send_delta();
      send_event();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("midi_track_event_parser_test passed");
    end else begin
      $display("midi_track_event_parser_test failed");
    end
    $finish;
  end

endmodule
